/* hw/rtl/assert_macros.svh */
// Assertion helper macros used by the RTL top level.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* hw/rtl/mpq_pkg.sv */
// Types and constants for the multilevel priority FIFO.
// No dependencies.
`default_nettype none
package mpq_pkg;
	localparam int unsigned FUNC_W = 3;
	localparam int unsigned HIN_W  = 16;
	localparam int unsigned PRIO_W = 4;
	localparam int unsigned TOP_W  = 3;

	typedef enum logic [FUNC_W-1:0] {
		FN_ENQ    = 3'd0,
		FN_DEQ    = 3'd1,
		FN_URGENT = 3'd2,
		FN_REMOVE = 3'd3,
		FN_QUERY  = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SCAN,
		ST_SHIFT,
		ST_RESULT
	} state_t;

	// command payload; func stays raw so the unused codes pass through
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [HIN_W-1:0]  item_handle;
		logic [PRIO_W-1:0] priority_req;
	} cmd_t;

	typedef struct packed {
		logic [HIN_W-1:0] out_handle;
		logic             hit;
		logic [TOP_W-1:0] top_class;
	} rsp_t;
endpackage
`default_nettype wire

/* hw/rtl/mpq_if.sv */
// Valid/ready channel interface carrying a payload struct.
// No dependencies.
`default_nettype none
interface mpq_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/mpq_store.sv */
// Handle memory: all FIFO rows in one RAM, one write and one registered read.
// Depends on nothing else.
`default_nettype none
module mpq_store #(
	parameter int unsigned AW = 7,
	parameter int unsigned DW = 16
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* hw/rtl/multilevel_priority_fifo_unit.sv */
// Multilevel priority FIFO top level: sequencer, counts and the handle RAM.
// Depends on mpq_pkg, mpq_if, mpq_store and assert_macros.svh.
//
// Commands are handled one at a time. After a command transfer the block
// passes through the DECIDE state, the work states below and the RESULT
// state; the response is presented on the cycle after RESULT, and the next
// command is taken the cycle after the response transfer. Enqueue, query,
// unused codes and takes from an empty FIFO need no work states. A take
// reads the head of the row and then compacts the row through the single
// RAM port, with a read and then a write for each entry moved. A remove
// scans one entry per cycle, row by row, and then compacts behind the
// removed entry the same way; the worst case is a miss in a full urgent
// FIFO and a hit at the head of a full level. Counts reset to empty; the
// RAM is not cleared since only entries below a row's count are ever used.
`default_nettype none
`include "assert_macros.svh"
module multilevel_priority_fifo_unit #(
	parameter int unsigned LEVELS      = 6,
	parameter int unsigned DEPTH       = 16,
	parameter int unsigned HANDLE_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	mpq_if.sink   cmd,
	mpq_if.source rsp
);
	localparam int unsigned ROWS    = LEVELS + 1;
	localparam int unsigned RW      = $clog2(ROWS);
	localparam int unsigned CW      = $clog2(DEPTH + 1);
	localparam int unsigned IW      = $clog2(DEPTH);
	localparam int unsigned AW      = RW + IW;
	localparam int unsigned HW      = HANDLE_BITS;
	localparam int unsigned TOP_W_L = mpq_pkg::TOP_W;

	logic [CW-1:0] cnt_q [ROWS];
	mpq_pkg::state_t state_q, state_d;
	logic [mpq_pkg::FUNC_W-1:0] func_q;
	logic [HW-1:0]  h_q;
	logic           urg_q;
	logic [mpq_pkg::PRIO_W-1:0] lvl_q;
	logic [RW-1:0]  row_q;
	logic [CW-1:0]  idx_q;
	logic           second_q;   // remove: level row pass
	logic           rd_pend_q;  // RAM read issued last cycle
	logic [15:0]    oh_q;
	logic           hit_q;
	logic           rsp_v_q;

	logic           we;
	logic [AW-1:0]  waddr, raddr;
	logic [HW-1:0]  wdata, rdata;

	logic [RW-1:0]  first_row;
	logic           any_ne;
	logic [RW:0]    row_inc;
	logic [TOP_W_L-1:0] top_now;
	logic           lvl_ok;
	logic [mpq_pkg::PRIO_W:0] lvl_inc;
	logic [RW-1:0]  lvl_row;
	logic [RW-1:0]  enq_row;
	logic           enq_ok;
	logic [RW-1:0]  take_row;
	logic [CW-1:0]  cur_cnt;
	logic [CW-1:0]  idx_inc;
	logic           match;

	mpq_store #(.AW(AW), .DW(HW)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// lowest non-empty row
	always_comb begin
		first_row = '0;
		any_ne    = 1'b0;
		for (int r = ROWS - 1; r >= 0; r--) begin
			if (cnt_q[r] != '0) begin
				first_row = RW'(r);
				any_ne    = 1'b1;
			end
		end
	end

	assign row_inc = {1'b0, first_row} + 1'b1;
	assign top_now = any_ne ? TOP_W_L'(row_inc) : '0;

	assign lvl_ok  = ({28'd0, lvl_q} < 32'(LEVELS));
	assign lvl_inc = {1'b0, lvl_q} + 1'b1;
	assign lvl_row = RW'(lvl_inc);

	always_comb begin
		enq_row = '0;
		if (!urg_q && lvl_ok) enq_row = lvl_row;
		enq_ok = (urg_q || lvl_ok) && (cnt_q[enq_row] < CW'(DEPTH));
	end

	assign take_row = (func_q == mpq_pkg::FN_DEQ) ? first_row : '0;
	assign cur_cnt  = cnt_q[row_q];
	assign idx_inc  = idx_q + 1'b1;
	assign match    = rd_pend_q && (rdata == h_q);

	assign cmd.ready = (state_q == mpq_pkg::ST_IDLE) && !rsp_v_q;
	assign rsp.valid = rsp_v_q;
	assign rsp.data.out_handle = oh_q;
	assign rsp.data.hit        = hit_q;
	assign rsp.data.top_class  = top_now;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mpq_pkg::ST_IDLE:
				if (cmd.valid && cmd.ready) state_d = mpq_pkg::ST_DECIDE;
			mpq_pkg::ST_DECIDE: begin
				state_d = mpq_pkg::ST_RESULT;
				if (func_q == mpq_pkg::FN_DEQ && any_ne)
					state_d = mpq_pkg::ST_SHIFT;
				if (func_q == mpq_pkg::FN_URGENT && cnt_q[0] != '0)
					state_d = mpq_pkg::ST_SHIFT;
				if (func_q == mpq_pkg::FN_REMOVE)
					state_d = mpq_pkg::ST_SCAN;
			end
			mpq_pkg::ST_SCAN: begin
				if (match)
					state_d = mpq_pkg::ST_SHIFT;
				else if (idx_q >= cur_cnt) begin
					if (!second_q && !urg_q && lvl_ok)
						state_d = mpq_pkg::ST_SCAN;
					else
						state_d = mpq_pkg::ST_RESULT;
				end
			end
			mpq_pkg::ST_SHIFT:
				if (!rd_pend_q && (idx_inc >= cur_cnt))
					state_d = mpq_pkg::ST_RESULT;
			mpq_pkg::ST_RESULT:
				state_d = mpq_pkg::ST_IDLE;
			default: state_d = mpq_pkg::ST_IDLE;
		endcase
	end

	// RAM port control
	always_comb begin
		we    = 1'b0;
		waddr = {row_q, idx_q[IW-1:0]};
		wdata = rdata;
		raddr = {row_q, idx_q[IW-1:0]};
		unique case (state_q)
			mpq_pkg::ST_DECIDE: begin
				we    = (func_q == mpq_pkg::FN_ENQ) && enq_ok;
				waddr = {enq_row, cnt_q[enq_row][IW-1:0]};
				wdata = h_q;
				// head of the row a take will pop
				raddr = {take_row, {IW{1'b0}}};
			end
			mpq_pkg::ST_SHIFT: begin
				// read idx+1, then write it at idx
				raddr = {row_q, idx_inc[IW-1:0]};
				we    = rd_pend_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mpq_pkg::ST_IDLE;
			func_q    <= '0;
			h_q       <= '0;
			urg_q     <= 1'b0;
			lvl_q     <= '0;
			row_q     <= '0;
			idx_q     <= '0;
			second_q  <= 1'b0;
			rd_pend_q <= 1'b0;
			oh_q      <= '0;
			hit_q     <= 1'b0;
			for (int r = 0; r < ROWS; r++) cnt_q[r] <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				mpq_pkg::ST_IDLE:
					if (cmd.valid && cmd.ready) begin
						func_q    <= cmd.data.func;
						h_q       <= HW'(cmd.data.item_handle);
						urg_q     <= cmd.data.priority_req[mpq_pkg::PRIO_W-1];
						lvl_q     <= cmd.data.priority_req;
						oh_q      <= '0;
						hit_q     <= 1'b0;
						idx_q     <= '0;
						row_q     <= '0;
						second_q  <= 1'b0;
						rd_pend_q <= 1'b0;
					end
				mpq_pkg::ST_DECIDE: begin
					unique case (func_q)
						mpq_pkg::FN_ENQ: if (enq_ok) begin
							cnt_q[enq_row] <= cnt_q[enq_row] + 1'b1;
							hit_q <= 1'b1;
						end
						mpq_pkg::FN_DEQ, mpq_pkg::FN_URGENT: row_q <= take_row;
						mpq_pkg::FN_QUERY: hit_q <= any_ne;
						default: ;
					endcase
				end
				mpq_pkg::ST_SCAN: begin
					// one read issued per cycle, compared the cycle after
					if (match) begin
						hit_q     <= 1'b1;
						idx_q     <= idx_q - 1'b1;
						rd_pend_q <= 1'b0;
					end else if (idx_q < cur_cnt) begin
						idx_q     <= idx_inc;
						rd_pend_q <= 1'b1;
					end else begin
						rd_pend_q <= 1'b0;
						if (!second_q && !urg_q && lvl_ok) begin
							second_q <= 1'b1;
							row_q    <= lvl_row;
							idx_q    <= '0;
						end
					end
				end
				mpq_pkg::ST_SHIFT: begin
					// first cycle of a take sees the head read in DECIDE
					if (!hit_q) begin
						oh_q  <= 16'(rdata);
						hit_q <= 1'b1;
					end
					if (rd_pend_q) begin
						idx_q     <= idx_inc;
						rd_pend_q <= 1'b0;
					end else if (idx_inc >= cur_cnt) begin
						cnt_q[row_q] <= cur_cnt - 1'b1;
					end else begin
						rd_pend_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (state_q == mpq_pkg::ST_RESULT) begin
			rsp_v_q <= 1'b1;
		end else if (rsp.valid && rsp.ready) begin
			rsp_v_q <= 1'b0;
		end
	end

	`ASSERT_IMPL(a_rsp_hold, clk, arst_n, rsp_v_q, state_q != mpq_pkg::ST_DECIDE,
		"command in flight while result pending")
	`ASSERT_NEXT(a_result_valid, clk, arst_n, state_q == mpq_pkg::ST_RESULT, rsp_v_q,
		"result not raised")
	`ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1, cnt_q[0] <= CW'(DEPTH),
		"urgent count overflow")
endmodule
`default_nettype wire

/* verif/tb_top.sv */
// Testbench for multilevel_priority_fifo_unit: directed and random command streams,
// checked against a queue-based predictor of the urgent and level FIFOs.
// Depends on mpq_pkg, mpq_if and the RTL top level.
`timescale 1ns / 100ps
module tb_top;
	localparam int LEVELS = 6;
	localparam int DEPTH  = 16;
	localparam int ROWS   = LEVELS + 1;
	localparam int TOP_W  = mpq_pkg::TOP_W;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mpq_if #(.payload_t(mpq_pkg::cmd_t)) cmd ();
	mpq_if #(.payload_t(mpq_pkg::rsp_t)) rsp ();

	multilevel_priority_fifo_unit #(
		.LEVELS(LEVELS), .DEPTH(DEPTH), .HANDLE_BITS(16)
	) DUT (
		.clk(clk), .arst_n(arst_n), .cmd(cmd.sink), .rsp(rsp.source)
	);

	always #4 clk = ~clk;

	// row 0 is the urgent FIFO, row 1+L is level L
	logic [mpq_pkg::HIN_W-1:0] fifo_rows[ROWS][$];
	mpq_pkg::rsp_t expected_rsp[$];
	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	initial begin
		cmd.valid = 1'b0;
		cmd.data = '0;
		rsp.ready = 1'b0;
	end

	function automatic logic [TOP_W-1:0] top_now();
		for (int r = 0; r < ROWS; r++)
			if (fifo_rows[r].size() != 0) return TOP_W'(r + 1);
		return '0;
	endfunction

	function automatic bit drop_handle(int row, logic [mpq_pkg::HIN_W-1:0] h);
		for (int i = 0; i < fifo_rows[row].size(); i++)
			if (fifo_rows[row][i] == h) begin
				fifo_rows[row].delete(i);
				return 1'b1;
			end
		return 1'b0;
	endfunction

	function automatic mpq_pkg::rsp_t predict_queue_op(mpq_pkg::cmd_t c);
		mpq_pkg::rsp_t r;
		bit urgent;
		int row;
		r = '0;
		urgent = c.priority_req[mpq_pkg::PRIO_W-1];
		case (c.func)
			mpq_pkg::FN_ENQ: begin
				row = urgent ? 0 : (c.priority_req < LEVELS ? c.priority_req + 1 : -1);
				if (row >= 0 && fifo_rows[row].size() < DEPTH) begin
					fifo_rows[row].push_back(c.item_handle);
					r.hit = 1'b1;
				end
			end
			mpq_pkg::FN_DEQ: begin
				for (int i = 0; i < ROWS; i++)
					if (fifo_rows[i].size() != 0) begin
						r.out_handle = fifo_rows[i].pop_front();
						r.hit = 1'b1;
						break;
					end
			end
			mpq_pkg::FN_URGENT: begin
				if (fifo_rows[0].size() != 0) begin
					r.out_handle = fifo_rows[0].pop_front();
					r.hit = 1'b1;
				end
			end
			mpq_pkg::FN_REMOVE: begin
				r.hit = drop_handle(0, c.item_handle);
				if (!r.hit && !urgent && c.priority_req < LEVELS)
					r.hit = drop_handle(c.priority_req + 1, c.item_handle);
			end
			mpq_pkg::FN_QUERY: r.hit = (top_now() != 0);
			default: ;
		endcase
		r.top_class = top_now();
		return r;
	endfunction

	task automatic send_cmd(logic [2:0] f, logic [15:0] h, logic [3:0] p);
		mpq_pkg::cmd_t c;
		c.func = f;
		c.item_handle = h;
		c.priority_req = p;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			cmd.valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		cmd.valid = 1'b1;
		cmd.data = c;
		do @(posedge clk); while (!cmd.ready);
		expected_rsp.push_back(predict_queue_op(c));
		n_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		cmd.valid = 1'b0;
		while (expected_rsp.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	always @(negedge clk)
		rsp.ready = ($urandom_range(0, 99) >= recv_stall_pct);

	always @(posedge clk) begin
		mpq_pkg::rsp_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			n_checked++;
			if (expected_rsp.size() == 0) begin
				errors++;
				$display("%0t: unexpected transfer, actual %h", $time, rsp.data);
			end else begin
				e = expected_rsp.pop_front();
				if (rsp.data.out_handle !== e.out_handle) begin
					errors++;
					$display("%0t: out_handle expected %h actual %h", $time,
						e.out_handle, rsp.data.out_handle);
				end
				if (rsp.data.hit !== e.hit) begin
					errors++;
					$display("%0t: hit expected %b actual %b", $time, e.hit, rsp.data.hit);
				end
				if (rsp.data.top_class !== e.top_class) begin
					errors++;
					$display("%0t: top_class expected %0d actual %0d", $time,
						e.top_class, rsp.data.top_class);
				end
			end
		end
	end

	task automatic test_directed();
		send_cmd(mpq_pkg::FN_QUERY, 16'h0000, 4'd0);
		send_cmd(mpq_pkg::FN_DEQ, 16'h0000, 4'd0);
		send_cmd(mpq_pkg::FN_URGENT, 16'h0000, 4'd0);
		send_cmd(mpq_pkg::FN_REMOVE, 16'hFFFF, 4'hF);
		send_cmd(mpq_pkg::FN_ENQ, 16'hFFFF, 4'd5);
		send_cmd(mpq_pkg::FN_ENQ, 16'h0000, 4'd0);
		send_cmd(mpq_pkg::FN_ENQ, 16'hA5A5, 4'd6);
		send_cmd(mpq_pkg::FN_ENQ, 16'h5A5A, 4'd7);
		send_cmd(mpq_pkg::FN_ENQ, 16'h1234, 4'hF);
		send_cmd(mpq_pkg::FN_ENQ, 16'h4321, 4'h8);
		send_cmd(mpq_pkg::FN_QUERY, 16'hFFFF, 4'hF);
		send_cmd(mpq_pkg::FN_REMOVE, 16'hFFFF, 4'd7);
		send_cmd(mpq_pkg::FN_REMOVE, 16'hFFFF, 4'd5);
		send_cmd(3'd5, 16'hFFFF, 4'hF);
		send_cmd(3'd6, 16'h0000, 4'd0);
		send_cmd(3'd7, 16'hFFFF, 4'd0);
		send_cmd(mpq_pkg::FN_URGENT, 16'h0000, 4'd0);
		send_cmd(mpq_pkg::FN_DEQ, 16'h0000, 4'd0);
		send_cmd(mpq_pkg::FN_DEQ, 16'h0000, 4'd0);
		// fill level 3 past its depth, remove two handles, then empty it with takes
		for (int i = 0; i <= DEPTH; i++) send_cmd(mpq_pkg::FN_ENQ, 16'(i), 4'd3);
		send_cmd(mpq_pkg::FN_REMOVE, 16'd7, 4'd3);
		send_cmd(mpq_pkg::FN_REMOVE, 16'd0, 4'd3);
		for (int i = 0; i < DEPTH; i++) send_cmd(mpq_pkg::FN_DEQ, 16'h0000, 4'd0);
	endtask

	task automatic test_random(int n);
		logic [2:0] f;
		logic [15:0] h;
		logic [3:0] p;
		int k;
		int r;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			p = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(8, 15))
				: 4'($urandom_range(0, 5));
			if ($urandom_range(0, 19) == 0) p = 4'($urandom);
			h = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 15)) : 16'($urandom);
			if (k < 45) f = mpq_pkg::FN_ENQ;
			else if (k < 65) f = mpq_pkg::FN_DEQ;
			else if (k < 75) f = mpq_pkg::FN_URGENT;
			else if (k < 92) begin
				f = mpq_pkg::FN_REMOVE;
				r = $urandom_range(0, ROWS - 1);
				if (fifo_rows[r].size() != 0 && $urandom_range(0, 3) != 0) begin
					h = fifo_rows[r][$urandom_range(0, fifo_rows[r].size() - 1)];
					if (r != 0) p = 4'(r - 1);
				end
			end else if (k < 97) f = mpq_pkg::FN_QUERY;
			else f = 3'($urandom_range(5, 7));
			send_cmd(f, h, p);
		end
	endtask

	task automatic test_idle_phases();
		int pct_s[4] = '{0, 66, 0, 11};
		int pct_r[4] = '{0, 0, 66, 11};
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = pct_s[ph];
			recv_stall_pct = pct_r[ph];
			test_random(200);
			if (ph == 1) wait_drained();
			test_random(195);
			wait_drained();
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);
		test_directed();
		wait_drained();
		test_idle_phases();
		cmd.valid = 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("Run: %0d commands sent, %0d responses checked, all idle/stall phases",
			n_sent, n_checked);
		if (errors == 0 && expected_rsp.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#20ms;
		$display("Timeout with %0d responses outstanding", expected_rsp.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/mpq_pkg.sv
hw/rtl/mpq_if.sv
hw/rtl/mpq_store.sv
hw/rtl/multilevel_priority_fifo_unit.sv
verif/tb_top.sv
